@@ sv/lcal_pkg.sv @@
package lcal_pkg;

   localparam int NODE_W    = 10;
   localparam int MAX_NODES = 1 << NODE_W;
   localparam int ENTRY_W   = NODE_W + 1;
   localparam int COUNT_W   = NODE_W + 1;

   // Table entry with all ones marks "no ancestor"
   localparam logic [ENTRY_W-1:0] NO_ANC      = '1;
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_NODES);

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_BUILD = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   localparam logic RES_QUERY = 1'b0;
   localparam logic RES_BUILD = 1'b1;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic [NODE_W-1:0] node_depth;
   } req_item_type;

   typedef struct packed {
      logic              result_kind;
      logic [NODE_W-1:0] ancestor;
   } rsp_item_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_CAPTURE,
      OP_BUILD_START,
      OP_RD_DEPTHS,
      OP_ORDER,
      OP_RD_P,
      OP_DEC,
      OP_MOVE_P,
      OP_TAKE_DP,
      OP_EQ_PREP,
      OP_RD_PQ_TAB,
      OP_JOIN_STEP,
      OP_RD_PAR_P,
      OP_SET_RES_PAR,
      OP_RD_PAR_IDX,
      OP_RD_MID,
      OP_RD_ANC,
      OP_WR_INV,
      OP_WR_PAR,
      OP_WR_ANC,
      OP_SET_RES_BUILD,
      OP_PUSH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic need_lift;
      logic up_valid;
      logic lvl_zero;
      logic pq_equal;
      logic entry_active;
      logic build_last;
   } dp_stat_type;

endpackage

@@ sv/lcal_ctrl.sv @@
module lcal_ctrl
   import lcal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_kind,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_B_CHK,
      S_B_L0_WR,
      S_B_MID,
      S_B_ANC_WR,
      S_B_DONE,
      S_Q_DEPTH,
      S_Q_ORDER,
      S_Q_UP_CHK,
      S_Q_UP_MOVE,
      S_Q_UP_DEP,
      S_Q_EQ,
      S_Q_JOIN_RD,
      S_Q_JOIN_MOVE,
      S_Q_PAR_RD,
      S_Q_PAR_RES,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;
   dp_op_type op;

   assign req_stall = req_stall_ff;
   assign cmd.op    = op;

   always_comb begin
      state_in = state_ff;
      op       = OP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall_ff) begin
               unique case (req_kind)
                  REQ_LOAD: begin
                     op = OP_LOAD;
                  end
                  REQ_BUILD: begin
                     op       = OP_BUILD_START;
                     state_in = S_B_CHK;
                  end
                  REQ_QUERY: begin
                     op       = OP_CAPTURE;
                     state_in = S_Q_DEPTH;
                  end
                  default: ;
               endcase
            end
         end
         S_B_CHK: begin
            if (!stat.entry_active) begin
               op       = OP_WR_INV;
               state_in = stat.build_last ? S_B_DONE : S_B_CHK;
            end else if (stat.lvl_zero) begin
               op       = OP_RD_PAR_IDX;
               state_in = S_B_L0_WR;
            end else begin
               op       = OP_RD_MID;
               state_in = S_B_MID;
            end
         end
         S_B_L0_WR: begin
            op       = OP_WR_PAR;
            state_in = stat.build_last ? S_B_DONE : S_B_CHK;
         end
         S_B_MID: begin
            if (stat.up_valid) begin
               op       = OP_RD_ANC;
               state_in = S_B_ANC_WR;
            end else begin
               op       = OP_WR_INV;
               state_in = stat.build_last ? S_B_DONE : S_B_CHK;
            end
         end
         S_B_ANC_WR: begin
            op       = OP_WR_ANC;
            state_in = stat.build_last ? S_B_DONE : S_B_CHK;
         end
         S_B_DONE: begin
            op       = OP_SET_RES_BUILD;
            state_in = S_OUT;
         end
         S_Q_DEPTH: begin
            op       = OP_RD_DEPTHS;
            state_in = S_Q_ORDER;
         end
         S_Q_ORDER: begin
            op       = OP_ORDER;
            state_in = S_Q_UP_CHK;
         end
         S_Q_UP_CHK: begin
            if (stat.need_lift) begin
               op       = OP_RD_P;
               state_in = S_Q_UP_MOVE;
            end else if (stat.lvl_zero) begin
               state_in = S_Q_EQ;
            end else begin
               op = OP_DEC;
            end
         end
         S_Q_UP_MOVE: begin
            if (stat.up_valid) begin
               op       = OP_MOVE_P;
               state_in = S_Q_UP_DEP;
            end else if (stat.lvl_zero) begin
               state_in = S_Q_EQ;
            end else begin
               op       = OP_DEC;
               state_in = S_Q_UP_CHK;
            end
         end
         S_Q_UP_DEP: begin
            op       = OP_TAKE_DP;
            state_in = stat.lvl_zero ? S_Q_EQ : S_Q_UP_CHK;
         end
         S_Q_EQ: begin
            op       = OP_EQ_PREP;
            state_in = stat.pq_equal ? S_OUT : S_Q_JOIN_RD;
         end
         S_Q_JOIN_RD: begin
            op       = OP_RD_PQ_TAB;
            state_in = S_Q_JOIN_MOVE;
         end
         S_Q_JOIN_MOVE: begin
            op       = OP_JOIN_STEP;
            state_in = stat.lvl_zero ? S_Q_PAR_RD : S_Q_JOIN_RD;
         end
         S_Q_PAR_RD: begin
            op       = OP_RD_PAR_P;
            state_in = S_Q_PAR_RES;
         end
         S_Q_PAR_RES: begin
            op       = OP_SET_RES_PAR;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               op       = OP_PUSH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_IDLE);
      end
   end

`ifndef ASSERT_OFF
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == S_IDLE))
      else $error("item accepted outside idle");

   a_query_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == REQ_QUERY)
      |=> (state_ff == S_Q_DEPTH && req_stall))
      else $error("query item did not start the depth read");
`endif

endmodule

@@ sv/lcal_dp.sv @@
module lcal_dp
   import lcal_pkg::*;
#(
   parameter int LIFT_LEVELS = 10
)
(
   input  logic               clock,
   input  logic               reset,
   input  req_item_type       req_data,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output rsp_item_type       rsp_data
);

   localparam int LVL_W     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int TAB_DEPTH = LIFT_LEVELS * MAX_NODES;
   localparam int TAB_AW    = $clog2(TAB_DEPTH);
   localparam int ADDR_W    = LVL_W + NODE_W;
   localparam int CMP_W     = (((1 << LVL_W) > COUNT_W) ? (1 << LVL_W) : COUNT_W) + 2;

   logic [NODE_W-1:0]  parent_store_ff [0:MAX_NODES-1];
   logic [NODE_W-1:0]  depth_store_ff  [0:MAX_NODES-1];
   logic [ENTRY_W-1:0] lift_table_ff   [0:TAB_DEPTH-1];

   logic [COUNT_W-1:0] node_count_ff;
   logic [NODE_W-1:0]  p_ff, q_ff, dp_ff, dq_ff, idx_ff;
   logic [NODE_W-1:0]  dep_a_ff, dep_b_ff, par_rd_ff, res_ff;
   logic [ENTRY_W-1:0] tab_a_ff, tab_b_ff;
   logic [LVL_W-1:0]   lvl_ff, top_ff;
   logic               res_kind_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff;

   logic [COUNT_W-1:0] n_eff;
   logic [LVL_W-1:0]   lvl_dec, lvl_prev, top_in;
   logic [CMP_W-1:0]   step;
   logic [NODE_W-1:0]  dep_max;
   logic [ADDR_W-1:0]  tab_wr_addr, tab_rd_addr_a, tab_rd_addr_b;
   logic [ENTRY_W-1:0] tab_wr_data;
   logic               tab_we, tab_a_en, tab_b_en;
   logic [NODE_W-1:0]  dep_addr_a, par_addr;
   logic               dep_a_en, dep_b_en, par_en;
   logic               join_move;

   // Highest set bit of the depth, at least one, capped at the top table level
   function automatic logic [LVL_W-1:0] top_level(input logic [NODE_W-1:0] d);
      logic [4:0] t;
      t = 5'd1;
      for (int k = 2; k < NODE_W; k++) begin
         if (|(d >> k)) t = 5'(k);
      end
      if (t > 5'(LIFT_LEVELS - 1)) t = 5'(LIFT_LEVELS - 1);
      return t[LVL_W-1:0];
   endfunction

   assign n_eff    = (node_count_ff > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
                                                             : node_count_ff;
   assign lvl_dec  = (lvl_ff == '0) ? '0 : lvl_ff - LVL_W'(1);
   assign lvl_prev = lvl_ff - LVL_W'(1);
   assign step     = CMP_W'(1) << lvl_ff;
   assign dep_max  = (dep_a_ff < dep_b_ff) ? dep_b_ff : dep_a_ff;
   assign top_in   = top_level(dep_max);

   assign join_move = (tab_a_ff != NO_ANC) && (tab_b_ff != NO_ANC) && (tab_a_ff != tab_b_ff);

   assign stat.out_free     = !rsp_valid_ff || !rsp_stall;
   assign stat.need_lift    = CMP_W'(dp_ff) >= (CMP_W'(dq_ff) + step);
   assign stat.up_valid     = (tab_a_ff != NO_ANC);
   assign stat.lvl_zero     = (lvl_ff == '0);
   assign stat.pq_equal     = (p_ff == q_ff);
   assign stat.entry_active = (COUNT_W'(idx_ff) < n_eff)
                              && ((lvl_ff == '0) || (step < CMP_W'(n_eff)));
   assign stat.build_last   = (idx_ff == '1) && (lvl_ff == LVL_W'(LIFT_LEVELS - 1));

   // Memory address and enable selection
   always_comb begin
      tab_wr_addr   = {lvl_ff, idx_ff};
      tab_rd_addr_a = {lvl_ff, p_ff};
      tab_rd_addr_b = {lvl_ff, q_ff};
      tab_wr_data   = NO_ANC;
      tab_we        = 1'b0;
      tab_a_en      = 1'b0;
      tab_b_en      = 1'b0;
      dep_addr_a    = p_ff;
      dep_a_en      = 1'b0;
      dep_b_en      = 1'b0;
      par_addr      = p_ff;
      par_en        = 1'b0;
      case (cmd.op)
         OP_RD_P: begin
            tab_a_en = 1'b1;
         end
         OP_RD_PQ_TAB: begin
            tab_a_en = 1'b1;
            tab_b_en = 1'b1;
         end
         OP_RD_MID: begin
            tab_rd_addr_a = {lvl_prev, idx_ff};
            tab_a_en      = 1'b1;
         end
         OP_RD_ANC: begin
            tab_rd_addr_b = {lvl_prev, tab_a_ff[NODE_W-1:0]};
            tab_b_en      = 1'b1;
         end
         OP_WR_INV: begin
            tab_we = 1'b1;
         end
         OP_WR_PAR: begin
            tab_wr_data = {1'b0, par_rd_ff};
            tab_we      = 1'b1;
         end
         OP_WR_ANC: begin
            tab_wr_data = tab_b_ff;
            tab_we      = 1'b1;
         end
         OP_RD_DEPTHS: begin
            dep_a_en = 1'b1;
            dep_b_en = 1'b1;
         end
         OP_MOVE_P: begin
            dep_addr_a = tab_a_ff[NODE_W-1:0];
            dep_a_en   = 1'b1;
         end
         OP_RD_PAR_IDX: begin
            par_addr = idx_ff;
            par_en   = 1'b1;
         end
         OP_RD_PAR_P: begin
            par_en = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         parent_store_ff[req_data.node_a] <= req_data.node_b;
         depth_store_ff[req_data.node_a]  <= req_data.node_depth;
      end
      if (tab_we) lift_table_ff[tab_wr_addr[TAB_AW-1:0]] <= tab_wr_data;
      if (tab_a_en) tab_a_ff <= lift_table_ff[tab_rd_addr_a[TAB_AW-1:0]];
      if (tab_b_en) tab_b_ff <= lift_table_ff[tab_rd_addr_b[TAB_AW-1:0]];
      if (dep_a_en) dep_a_ff <= depth_store_ff[dep_addr_a];
      if (dep_b_en) dep_b_ff <= depth_store_ff[q_ff];
      if (par_en) par_rd_ff <= parent_store_ff[par_addr];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            p_ff <= req_data.node_a;
            q_ff <= req_data.node_b;
         end
         OP_BUILD_START: begin
            lvl_ff <= '0;
            idx_ff <= '0;
         end
         OP_ORDER: begin
            // Put the deeper node in p
            if (dep_a_ff < dep_b_ff) begin
               p_ff  <= q_ff;
               q_ff  <= p_ff;
               dp_ff <= dep_b_ff;
               dq_ff <= dep_a_ff;
            end else begin
               dp_ff <= dep_a_ff;
               dq_ff <= dep_b_ff;
            end
            lvl_ff <= top_in;
            top_ff <= top_in;
         end
         OP_DEC: begin
            lvl_ff <= lvl_dec;
         end
         OP_MOVE_P: begin
            p_ff <= tab_a_ff[NODE_W-1:0];
         end
         OP_TAKE_DP: begin
            dp_ff  <= dep_a_ff;
            lvl_ff <= lvl_dec;
         end
         OP_EQ_PREP: begin
            lvl_ff      <= top_ff;
            res_ff      <= p_ff;
            res_kind_ff <= RES_QUERY;
         end
         OP_JOIN_STEP: begin
            if (join_move) begin
               p_ff <= tab_a_ff[NODE_W-1:0];
               q_ff <= tab_b_ff[NODE_W-1:0];
            end
            lvl_ff <= lvl_dec;
         end
         OP_SET_RES_PAR: begin
            res_ff      <= par_rd_ff;
            res_kind_ff <= RES_QUERY;
         end
         OP_SET_RES_BUILD: begin
            res_ff      <= '0;
            res_kind_ff <= RES_BUILD;
         end
         OP_WR_INV, OP_WR_PAR, OP_WR_ANC: begin
            // Advance to the next node, then the next level
            idx_ff <= idx_ff + NODE_W'(1);
            if (idx_ff == '1) lvl_ff <= lvl_ff + LVL_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_PUSH) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_PUSH) begin
         rsp_item_ff.result_kind <= res_kind_ff;
         rsp_item_ff.ancestor    <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

`ifndef ASSERT_OFF
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUSH) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result pushed over a pending item");

   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.op == OP_PUSH))
      else $error("result valid raised without a push");
`endif

endmodule

@@ sv/lowest_common_ancestor_lifting.sv @@
// Lowest common ancestor by binary lifting over a tree of up to 1024 nodes.
// Input channel req_*: each item is a load (node_a gets parent node_b and
// depth node_depth), a build of the ancestor table, or a query of the pair
// node_a, node_b. Result channel rsp_*: a query answers with the ancestor,
// a build answers with result_kind set once the table is complete; a load
// and the unused request code give no result.
// csr_wr_en/csr_wr_data set node_count (nodes covered by a build); write it
// only while the block is idle. Reset sets it to 1024.
// Operation: a load writes the parent and depth stores and leaves the block idle.
// A query reads both depths, orders the pair, lifts the deeper node level by level
// from the top table level and, unless the pair then meets, walks both nodes up
// together, ending with a parent read. The table memory is read one step at a time.
// A build sweeps every entry of every level, filling a node below node_count
// from its parent at level zero and from the level below where node_count reaches.
// One item is processed at a time; req_stall is high while it runs.
// A finished result sits in the output register while the next item is
// taken. If rsp_stall holds it, the following result waits for that register.
// Reset clears the control state and the output valid; the parent, depth and
// ancestor stores are not cleared, so load the tree and build before a query.
module lowest_common_ancestor_lifting
   import lcal_pkg::*;
#(
   parameter int LIFT_LEVELS = 10
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_item_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_item_type       rsp_data,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   lcal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lcal_dp #(
      .LIFT_LEVELS (LIFT_LEVELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule
